// ===== sv/qspp_pkg.sv =====
package qspp_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [4:0] HEX_BASE   = 5'd16;

    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_NEWPAIR = 3'd1,
        PH_KEY     = 3'd2,
        PH_VALUE   = 3'd3,
        PH_ERROR   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        K_CHAR = 2'd0,
        K_ESC  = 2'd1,
        K_CTRL = 2'd2
    } kind_t;

    // classified word handed from front to back
    typedef struct packed {
        kind_t      kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       in_value;
        logic       part_end;
        logic [1:0] status;
    } word_t;

endpackage

// ===== sv/qspp_front.sv =====
module qspp_front
    import qspp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       end_of_query,
    output logic       wr,
    output word_t      wd
);

    phase_t     phase_reg, phase_next;
    logic [1:0] esc_reg, esc_next;
    logic [7:0] first_reg, first_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            esc_reg   <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_reg <= first_next;
        end
    end

    always_comb
    begin
        logic [1:0] esc_in;
        logic       inval;
        logic       decode;
        phase_next  = phase_reg;
        esc_next    = esc_reg;
        first_next  = first_reg;
        wr          = 1'b0;
        wd.kind     = K_CTRL;
        wd.b0       = in_byte;
        wd.b1       = in_byte;
        wd.in_value = 1'b0;
        wd.part_end = 1'b0;
        wd.status   = ST_RUNNING;
        esc_in      = esc_reg;
        inval       = 1'b0;
        decode      = 1'b0;

        if (end_of_query)
        begin
            phase_next = PH_START;
            esc_next   = 2'd0;
            unique case (phase_reg)
                PH_START:
                begin
                    wr        = 1'b1;
                    wd.status = ST_DONE;
                end
                PH_NEWPAIR, PH_KEY:
                begin
                    wr        = 1'b1;
                    wd.status = ST_ERROR;
                end
                PH_VALUE:
                begin
                    wr          = 1'b1;
                    wd.in_value = 1'b1;
                    wd.part_end = 1'b1;
                    wd.status   = ST_DONE;
                end
                default: ;
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_START, PH_NEWPAIR:
                begin
                    esc_next = 2'd0;
                    if (in_byte == CH_AMP || in_byte == CH_EQUALS)
                    begin
                        phase_next = PH_ERROR;
                        wr         = 1'b1;
                        wd.status  = ST_ERROR;
                    end
                    else
                    begin
                        phase_next = PH_KEY;
                        esc_in     = 2'd0;
                        decode     = 1'b1;
                    end
                end
                PH_KEY:
                begin
                    if (in_byte == CH_EQUALS)
                    begin
                        phase_next  = PH_VALUE;
                        esc_next    = 2'd0;
                        wr          = 1'b1;
                        wd.part_end = 1'b1;
                    end
                    else
                    begin
                        decode = 1'b1;
                    end
                end
                PH_VALUE:
                begin
                    inval = 1'b1;
                    if (in_byte == CH_AMP)
                    begin
                        phase_next  = PH_NEWPAIR;
                        esc_next    = 2'd0;
                        wr          = 1'b1;
                        wd.in_value = 1'b1;
                        wd.part_end = 1'b1;
                    end
                    else
                    begin
                        decode = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_ERROR;
                end
            endcase

            if (decode)
            begin
                wd.in_value = inval;
                priority if (esc_in == 2'd1)
                begin
                    first_next = in_byte;
                    esc_next   = 2'd2;
                end
                else if (esc_in == 2'd2)
                begin
                    esc_next = 2'd0;
                    wr       = 1'b1;
                    wd.kind  = K_ESC;
                    wd.b0    = first_reg;
                end
                else if (in_byte == CH_PERCENT)
                begin
                    esc_next = 2'd1;
                end
                else
                begin
                    esc_next = 2'd0;
                    wr       = 1'b1;
                    wd.kind  = K_CHAR;
                end
            end
        end
    end

endmodule

// ===== sv/qspp_fifo.sv =====
module qspp_fifo
    import qspp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr,
    input  word_t wr_data,
    output logic  full,
    input  logic  rd,
    output logic  avail,
    output word_t rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    word_t         mem_reg [DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;

    assign full    = (cnt_reg == FULL_CNT);
    assign avail   = (cnt_reg != '0);
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= (wp_reg == LAST) ? '0 : wp_reg + 1'b1;
            end
            if (rd)
            begin
                rp_reg <= (rp_reg == LAST) ? '0 : rp_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(wr && full))
        else $error("word written into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(rd && !avail))
        else $error("word read from empty queue");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= FULL_CNT)
        else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wp_reg == rp_reg))
        else $error("pointers disagree with empty count");

endmodule

// ===== sv/qspp_back.sv =====
module qspp_back
    import qspp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       avail,
    input  word_t      wd,
    output logic       rd,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       in_value,
    output logic       part_end,
    output logic [1:0] query_status
);

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    logic       vld_reg;
    logic [7:0] byte_reg, byte_next;
    logic       has_reg, has_next;
    logic       inv_reg;
    logic       pend_reg;
    logic [1:0] st_reg;

    assign rd           = avail && (!vld_reg || pop);
    assign empty        = !vld_reg;
    assign out_byte     = byte_reg;
    assign has_byte     = has_reg;
    assign in_value     = inv_reg;
    assign part_end     = pend_reg;
    assign query_status = st_reg;

    always_comb
    begin
        logic [4:0] h1;
        logic [4:0] h2;
        logic [7:0] hi;
        h1 = hex_val(wd.b0);
        h2 = hex_val(wd.b1);
        hi = 8'(h1[3:0]) * 8'(HEX_BASE);
        unique case (wd.kind)
            K_CHAR:
            begin
                byte_next = (wd.b0 == CH_PLUS) ? CH_SPACE : wd.b0;
                has_next  = 1'b1;
            end
            K_ESC:
            begin
                if (!h1[4])
                begin
                    byte_next = 8'd0;
                end
                else if (h2[4])
                begin
                    byte_next = hi | {4'd0, h2[3:0]};
                end
                else
                begin
                    byte_next = {4'd0, h1[3:0]};
                end
                has_next = 1'b1;
            end
            default:
            begin
                byte_next = 8'd0;
                has_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (rd)
        begin
            vld_reg <= 1'b1;
        end
        else if (pop)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd)
        begin
            byte_reg <= byte_next;
            has_reg  <= has_next;
            inv_reg  <= wd.in_value;
            pend_reg <= wd.part_end;
            st_reg   <= wd.status;
        end
    end

endmodule

// ===== sv/query_string_pair_parser.sv =====
// An accepted word goes into the queue, then into the result register on the ports. One
// word per cycle in while full is low, out while pop keeps up; at most one result per input
// word. The DEPTH-deep queue (four by default) between classifier and decoder sets when full rises.
// Reset (rst_n low, asynchronous): queue and result register empty, parser at
// query start with no escape pending.
module query_string_pair_parser
    import qspp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       end_of_query,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       in_value,
    output logic       part_end,
    output logic [1:0] query_status
);

    logic  accept;
    logic  f_req;
    logic  f_wr;
    word_t f_wd;
    logic  q_rd;
    logic  q_avail;
    word_t q_wd;

    assign accept = push && !full;
    assign f_wr   = accept && f_req;

    qspp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (in_byte),
        .end_of_query (end_of_query),
        .wr           (f_req),
        .wd           (f_wd)
    );

    qspp_fifo #(.DEPTH(DEPTH)) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (f_wr),
        .wr_data (f_wd),
        .full    (full),
        .rd      (q_rd),
        .avail   (q_avail),
        .rd_data (q_wd)
    );

    qspp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .avail        (q_avail),
        .wd           (q_wd),
        .rd           (q_rd),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .has_byte     (has_byte),
        .in_value     (in_value),
        .part_end     (part_end),
        .query_status (query_status)
    );

endmodule
